// ----- src/owrs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owrs_pkg
// Shared types and constants for the 1-Wire ROM search engine.
// ----------------------------------------------------------------------------
package owrs_pkg;

  localparam int ROM_BITS_DEF = 64;   // default ROM length in bits
  localparam int ADDR_W       = 64;   // width of the reported ROM number
  localparam int POS_W        = 7;    // bit positions 0..64
  localparam int FAM_W        = 4;    // family discrepancy 0..8
  localparam int FAMILY_LIMIT = 9;    // positions below this lie in byte 0

  localparam logic OP_RESTART  = 1'b0;
  localparam logic OP_BIT_PAIR = 1'b1;

  typedef enum logic [2:0] {
    ST_TAKEN         = 3'd0,
    ST_FOUND         = 3'd1,
    ST_NO_RESPONSE   = 3'd2,
    ST_DONE          = 3'd3,
    ST_RESTARTED     = 3'd4,
    ST_FOUND_ZERO_FAM = 3'd5
  } owrs_status_t;

  // Enumeration bookkeeping carried between search triplets
  typedef struct packed {
    logic [POS_W-1:0] last_disc;
    logic [FAM_W-1:0] last_fam_disc;
    logic             last_dev;
    logic [POS_W-1:0] bit_pos;
    logic [POS_W-1:0] zero_pick;
  } owrs_ctr_t;

  // Per-item result apart from the ROM number
  typedef struct packed {
    logic             write_dir;
    owrs_status_t     status;
    logic             last_device;
    logic [FAM_W-1:0] family_discrepancy;
  } owrs_res_t;

endpackage

// ----- src/owrs_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owrs_in_if / owrs_out_if
// Valid/ready channels for search items and search results.
// ----------------------------------------------------------------------------
interface owrs_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] fam_byte;
  logic       targeted;
  logic       id_bit;
  logic       cmp_bit;

  modport source (output valid, op, fam_byte, targeted, id_bit, cmp_bit,
                  input ready);
  modport sink   (input valid, op, fam_byte, targeted, id_bit, cmp_bit,
                  output ready);
endinterface

interface owrs_out_if;
  logic        valid;
  logic        ready;
  logic        write_dir;
  logic [2:0]  status;
  logic [63:0] rom_address;
  logic        last_device;
  logic [3:0]  family_discrepancy;

  modport source (output valid, write_dir, status, rom_address, last_device,
                  family_discrepancy, input ready);
  modport sink   (input valid, write_dir, status, rom_address, last_device,
                  family_discrepancy, output ready);
endinterface

// ----- src/owrs_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owrs_step
// Combinational search step: decide one triplet or a restart, next state.
// ----------------------------------------------------------------------------
module owrs_step import owrs_pkg::*; #(
  parameter int ROM_BITS = ROM_BITS_DEF
) (
  input  logic                op,
  input  logic [7:0]          fam_byte,
  input  logic                targeted,
  input  logic                id_bit,
  input  logic                cmp_bit,
  input  owrs_ctr_t           ctr_cur,
  input  logic [ROM_BITS-1:0] rom_cur,
  output owrs_ctr_t           ctr_nxt,
  output logic [ROM_BITS-1:0] rom_nxt,
  output owrs_res_t           res
);

  localparam int IDX_W = (ROM_BITS > 1) ? $clog2(ROM_BITS) : 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(ROM_BITS);
  localparam logic [POS_W-1:0] FAM_LIM  = POS_W'(FAMILY_LIMIT);
  localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1);

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_m1;
  logic [IDX_W-1:0] idx;
  logic             dir;

  // Clamp a stray position back to the first bit
  always_comb begin
    pos = ctr_cur.bit_pos;
    if ((pos < POS_ONE) || (pos > LAST_POS)) begin
      pos = POS_ONE;
    end
    pos_m1 = pos - POS_ONE;
    idx    = pos_m1[IDX_W-1:0];
  end

  always_comb begin
    ctr_nxt = ctr_cur;
    rom_nxt = rom_cur;
    dir     = 1'b0;
    res.status = ST_TAKEN;

    if (op == OP_RESTART) begin
      ctr_nxt.last_disc     = '0;
      ctr_nxt.last_fam_disc = '0;
      ctr_nxt.last_dev      = 1'b0;
      if (targeted) begin
        rom_nxt           = ROM_BITS'(fam_byte);
        ctr_nxt.last_disc = LAST_POS;
      end else begin
        rom_nxt = '0;
      end
      ctr_nxt.bit_pos   = POS_ONE;
      ctr_nxt.zero_pick = '0;
      res.status        = ST_RESTARTED;
    end else if (ctr_cur.last_dev || (id_bit && cmp_bit)) begin
      // Drop the enumeration and start a new pass
      ctr_nxt.last_disc     = '0;
      ctr_nxt.last_fam_disc = '0;
      ctr_nxt.last_dev      = 1'b0;
      ctr_nxt.bit_pos       = POS_ONE;
      ctr_nxt.zero_pick     = '0;
      res.status            = ctr_cur.last_dev ? ST_DONE : ST_NO_RESPONSE;
    end else begin
      if (id_bit != cmp_bit) begin
        dir = id_bit;
      end else begin
        if (pos < ctr_cur.last_disc) begin
          dir = rom_cur[idx];
        end else begin
          dir = (pos == ctr_cur.last_disc);
        end
        if (!dir) begin
          ctr_nxt.zero_pick = pos;
          if (pos < FAM_LIM) begin
            ctr_nxt.last_fam_disc = pos[FAM_W-1:0];
          end
        end
      end
      rom_nxt[idx] = dir;

      if (pos < LAST_POS) begin
        ctr_nxt.bit_pos = pos + POS_ONE;
        res.status      = ST_TAKEN;
      end else begin
        ctr_nxt.last_disc = ctr_nxt.zero_pick;
        ctr_nxt.last_dev  = (ctr_nxt.zero_pick == '0);
        ctr_nxt.bit_pos   = POS_ONE;
        ctr_nxt.zero_pick = '0;
        if (rom_nxt[7:0] == 8'd0) begin
          ctr_nxt.last_disc     = '0;
          ctr_nxt.last_fam_disc = '0;
          ctr_nxt.last_dev      = 1'b0;
          res.status            = ST_FOUND_ZERO_FAM;
        end else begin
          res.status = ST_FOUND;
        end
      end
    end

    res.write_dir          = dir;
    res.last_device        = ctr_nxt.last_dev;
    res.family_discrepancy = ctr_nxt.last_fam_disc;
  end

endmodule

// ----- src/onewire_rom_search_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onewire_rom_search_engine
// Bit-level 1-Wire ROM search: one search triplet or restart per transaction.
// ----------------------------------------------------------------------------
//
//  channel  | dir | carries
//  ---------+-----+-------------------------------------------------------
//  in_ch    | in  | op, fam_byte, targeted, id_bit, cmp_bit
//  out_ch   | out | write_dir, status, rom_address, last_device,
//           |     | family_discrepancy
//
//  Throughput is one transaction per clock while out_ch is not stalled; the
//  result passes the input register, then the result register, before it
//  is valid on out_ch.
//  The search step is a single combinational pass between the two registers.
//  Synchronous active-low reset clears the search state (ROM number zero,
//  next bit position one) and both valid flags.
//  A stalled result holds the result register; the input register then
//  holds one more transaction and in_ch.ready drops only when both are full.
// ----------------------------------------------------------------------------
module onewire_rom_search_engine import owrs_pkg::*; #(
  parameter int ROM_BITS = ROM_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  owrs_in_if.sink     in_ch,
  owrs_out_if.source  out_ch
);

  // Input register
  logic       in_valid_r;
  logic       op_r;
  logic [7:0] fam_byte_r;
  logic       targeted_r;
  logic       id_bit_r;
  logic       cmp_bit_r;

  // Search state
  owrs_ctr_t           ctr_r;
  owrs_ctr_t           ctr_nxt;
  logic [ROM_BITS-1:0] rom_r;
  logic [ROM_BITS-1:0] rom_nxt;
  owrs_res_t           res;

  // Result register
  logic              out_valid_r;
  logic              write_dir_r;
  logic [2:0]        status_r;
  logic [ADDR_W-1:0] rom_address_r;
  logic              last_device_r;
  logic [FAM_W-1:0]  family_disc_r;

  logic advance;
  logic in_take;

  // Move the held item into the result register when it has room
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  owrs_step #(
    .ROM_BITS (ROM_BITS)
  ) u_step (
    .op          (op_r),
    .fam_byte    (fam_byte_r),
    .targeted    (targeted_r),
    .id_bit      (id_bit_r),
    .cmp_bit     (cmp_bit_r),
    .ctr_cur     (ctr_r),
    .rom_cur     (rom_r),
    .ctr_nxt     (ctr_nxt),
    .rom_nxt     (rom_nxt),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r       <= in_ch.op;
      fam_byte_r <= in_ch.fam_byte;
      targeted_r <= in_ch.targeted;
      id_bit_r   <= in_ch.id_bit;
      cmp_bit_r  <= in_ch.cmp_bit;
    end
  end

  // Commit the search state only when the item moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r.last_disc     <= '0;
      ctr_r.last_fam_disc <= '0;
      ctr_r.last_dev      <= 1'b0;
      ctr_r.bit_pos       <= POS_W'(1);
      ctr_r.zero_pick     <= '0;
      rom_r               <= '0;
    end else if (advance) begin
      ctr_r <= ctr_nxt;
      rom_r <= rom_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      write_dir_r   <= res.write_dir;
      status_r      <= res.status;
      rom_address_r <= ADDR_W'(rom_nxt);
      last_device_r <= res.last_device;
      family_disc_r <= res.family_discrepancy;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.write_dir          = write_dir_r;
  assign out_ch.status             = status_r;
  assign out_ch.rom_address        = rom_address_r;
  assign out_ch.last_device        = last_device_r;
  assign out_ch.family_discrepancy = family_disc_r;

endmodule

// ----- tb/owrs_search_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owrs_search_checker
// Watches the search item and search result channels of the ROM search
// engine. Predicts each result from its own copy of the enumeration state
// and compares every accepted result field by field, in order.
// ----------------------------------------------------------------------------
module owrs_search_checker import owrs_pkg::*; #(
  parameter int ROM_BITS = ROM_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  owrs_in_if          in_mon,
  owrs_out_if         out_mon,
  input  logic        end_check,
  output int unsigned fail_count
);

  localparam logic [63:0] ROM_MASK = {64{1'b1}} >> (64 - ROM_BITS);

  typedef struct packed {
    logic         write_dir;
    owrs_status_t status;
    logic [63:0]  rom_address;
    logic         last_device;
    logic [3:0]   family_discrepancy;
  } search_result_t;

  // Search state as the engine should hold it
  logic [63:0] rom_q;
  logic [6:0]  last_disc_q;
  logic [3:0]  fam_disc_q;
  logic        last_dev_q;
  logic [6:0]  bit_pos_q;
  logic [6:0]  zero_pos_q;

  search_result_t expected_results[$];
  search_result_t want;
  int unsigned    errors = 0;

  assign fail_count = errors;

  task automatic report_error(input string msg);
    $display("%0t MISMATCH: %s", $time, msg);
    errors++;
  endtask

  function automatic search_result_t snapshot(input logic dir, input owrs_status_t st);
    search_result_t r;
    r.write_dir          = dir;
    r.status             = st;
    r.rom_address        = rom_q & ROM_MASK;
    r.last_device        = last_dev_q;
    r.family_discrepancy = fam_disc_q;
    return r;
  endfunction

  task automatic clear_enumeration();
    last_disc_q = '0;
    fam_disc_q  = '0;
    last_dev_q  = 1'b0;
  endtask

  task automatic start_pass();
    bit_pos_q  = 7'd1;
    zero_pos_q = '0;
  endtask

  task automatic advance_search(input logic op, input logic [7:0] fam, input logic aimed,
                                input logic idb, input logic cmpb,
                                output search_result_t res);
    int   pos;
    logic dir;
    if (op == OP_RESTART) begin
      clear_enumeration();
      if (aimed) begin
        rom_q       = {56'd0, fam} & ROM_MASK;
        last_disc_q = 7'(ROM_BITS);
      end else begin
        rom_q = '0;
      end
      start_pass();
      res = snapshot(1'b0, ST_RESTARTED);
    end else if (last_dev_q) begin
      clear_enumeration();
      start_pass();
      res = snapshot(1'b0, ST_DONE);
    end else if (idb && cmpb) begin
      clear_enumeration();
      start_pass();
      res = snapshot(1'b0, ST_NO_RESPONSE);
    end else begin
      pos = bit_pos_q;
      if (pos < 1 || pos > ROM_BITS)
        pos = 1;
      if (idb != cmpb) begin
        dir = idb;
      end else begin
        if (pos < last_disc_q)
          dir = rom_q[pos-1];
        else
          dir = (pos == last_disc_q);
        if (!dir) begin
          zero_pos_q = 7'(pos);
          if (pos < FAMILY_LIMIT)
            fam_disc_q = 4'(pos);
        end
      end
      rom_q[pos-1] = dir;
      rom_q        = rom_q & ROM_MASK;
      if (pos < ROM_BITS) begin
        bit_pos_q = 7'(pos + 1);
        res = snapshot(dir, ST_TAKEN);
      end else begin
        last_disc_q = zero_pos_q;
        if (last_disc_q == 0)
          last_dev_q = 1'b1;
        start_pass();
        if (rom_q[7:0] == 8'd0) begin
          clear_enumeration();
          res = snapshot(dir, ST_FOUND_ZERO_FAM);
        end else begin
          res = snapshot(dir, ST_FOUND);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rom_q = '0;
      clear_enumeration();
      start_pass();
      expected_results.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        advance_search(in_mon.op, in_mon.fam_byte, in_mon.targeted,
                       in_mon.id_bit, in_mon.cmp_bit, want);
        expected_results.push_back(want);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          report_error("result with no search item pending");
        end else begin
          want = expected_results.pop_front();
          if (out_mon.write_dir !== want.write_dir)
            report_error($sformatf("write_dir exp %b got %b",
                                   want.write_dir, out_mon.write_dir));
          if (out_mon.status !== want.status)
            report_error($sformatf("status exp %0d got %0d", want.status, out_mon.status));
          if (out_mon.rom_address !== want.rom_address)
            report_error($sformatf("rom_address exp %h got %h",
                                   want.rom_address, out_mon.rom_address));
          if (out_mon.last_device !== want.last_device)
            report_error($sformatf("last_device exp %b got %b",
                                   want.last_device, out_mon.last_device));
          if (out_mon.family_discrepancy !== want.family_discrepancy)
            report_error($sformatf("family_discrepancy exp %0d got %0d",
                                   want.family_discrepancy, out_mon.family_discrepancy));
        end
      end
      if (end_check && expected_results.size() != 0)
        report_error($sformatf("%0d results never arrived", expected_results.size()));
    end
  end

endmodule

// ----- tb/tb_onewire_rom_search_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_onewire_rom_search_engine
// Drives restarts and search triplets into the ROM search engine and stalls
// its result channel. Most traffic replays whole enumerations against a
// small simulated bus of devices; blind passes and random noise fill in.
// Checking is left to owrs_search_checker.
// ----------------------------------------------------------------------------
module tb_onewire_rom_search_engine;
  import owrs_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic end_check = 1'b0;
  int unsigned fail_count;

  owrs_in_if  in_ch();
  owrs_out_if out_ch();

  // Idle odds in percent for each side, changed per phase
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // Transaction counts on each side; results are counted with nonblocking
  // updates so the stimulus thread always sees the value from before the edge
  int unsigned  items_sent = 0;
  int unsigned  results_seen = 0;
  logic         seen_dir = 1'b0;
  owrs_status_t seen_status = ST_TAKEN;
  logic         seen_last_dev = 1'b0;

  int episode_cnt = 0;

  onewire_rom_search_engine u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  owrs_search_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .end_check  (end_check),
    .fail_count (fail_count)
  );

  always #4 clk = ~clk;

  // Receiver: drop ready at random according to the current phase
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Remember the last accepted result; the bus model needs the written
  // direction to decide which devices stay on the bus
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen  <= results_seen + 1;
      seen_dir      <= out_ch.write_dir;
      seen_status   <= owrs_status_t'(out_ch.status);
      seen_last_dev <= out_ch.last_device;
    end
  end

  // Offer one search item and hold it until the engine takes the transaction.
  // Valid stays high afterwards so back-to-back items leave no gap.
  task automatic send_item(input logic op, input logic [7:0] fam, input logic aimed,
                           input logic idb, input logic cmpb);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.fam_byte <= fam;
    in_ch.targeted <= aimed;
    in_ch.id_bit   <= idb;
    in_ch.cmp_bit  <= cmpb;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Hold the sender until every sent item has produced its result
  task automatic wait_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_seen < items_sent);
  endtask

  // Enumerate a small set of devices that share most of their ROM bits.
  // Each triplet waits for its result: the written direction decides which
  // devices keep answering on the next bit.
  task automatic run_enumeration(input int n_dev, input bit zero_family, input bit aimed);
    logic [63:0] devs [4];
    logic [63:0] base;
    logic [3:0]  alive;
    logic        idb;
    logic        cmpb;
    int          lo;
    base = {$urandom, $urandom};
    if (zero_family)
      base[7:0] = 8'd0;
    else if (base[7:0] == 8'd0)
      base[7:0] = 8'd1;
    lo = zero_family ? 8 : 0;
    for (int d = 0; d < n_dev; d++) begin
      devs[d] = base;
      if (d != 0)
        for (int j = 0; j < $urandom_range(1, 3); j++)
          devs[d][$urandom_range(63, lo)] ^= 1'b1;
    end
    send_item(OP_RESTART, aimed ? base[7:0] : 8'($urandom), aimed, 1'($urandom), 1'($urandom));
    for (int p = 0; p <= n_dev; p++) begin
      alive = '0;
      for (int d = 0; d < n_dev; d++)
        alive[d] = 1'b1;
      for (int k = 0; k < 64; k++) begin
        idb  = 1'b1;
        cmpb = 1'b1;
        for (int d = 0; d < n_dev; d++) begin
          if (alive[d]) begin
            idb  &= devs[d][k];
            cmpb &= ~devs[d][k];
          end
        end
        send_item(OP_BIT_PAIR, 8'($urandom), 1'($urandom), idb, cmpb);
        wait_results();
        // Pass ended before bit 64: nobody answered
        if (k < 63 && seen_status != ST_TAKEN)
          return;
        for (int d = 0; d < n_dev; d++)
          if (devs[d][k] != seen_dir)
            alive[d] = 1'b0;
      end
      // Last device found: one more triplet must report the end
      if (seen_status == ST_FOUND && seen_last_dev) begin
        send_item(OP_BIT_PAIR, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
        return;
      end
    end
  endtask

  // Full passes sent without waiting for results, with made-up bus answers: collisions, never a silent bus
  task automatic run_blind_passes();
    int roll;
    send_item(OP_RESTART, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
    for (int p = 0; p < $urandom_range(1, 2); p++) begin
      for (int k = 0; k < 64; k++) begin
        roll = $urandom_range(99);
        if (roll < 12)
          send_item(OP_BIT_PAIR, 8'($urandom), 1'($urandom), 1'b0, 1'b0);
        else if (roll < 56)
          send_item(OP_BIT_PAIR, 8'($urandom), 1'($urandom), 1'b1, 1'b0);
        else
          send_item(OP_BIT_PAIR, 8'($urandom), 1'($urandom), 1'b0, 1'b1);
      end
    end
  endtask

  // Anything goes: restarts mid-pass, collisions, silent bus
  task automatic run_noise();
    for (int i = 0; i < $urandom_range(24, 4); i++)
      send_item(($urandom_range(9) < 8) ? OP_BIT_PAIR : OP_RESTART, 8'($urandom),
                1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Hard stop in case the engine hangs
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned budget;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_RESTART;
    in_ch.fam_byte = 8'd0;
    in_ch.targeted = 1'b0;
    in_ch.id_bit   = 1'b0;
    in_ch.cmp_bit  = 1'b0;
    out_ch.ready   = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: triplets straight out of reset, including a collision-free
    // pick, a discrepancy and a silent bus
    send_item(OP_BIT_PAIR, 8'hFF, 1'b1, 1'b1, 1'b0);
    send_item(OP_BIT_PAIR, 8'h00, 1'b0, 1'b0, 1'b1);
    send_item(OP_BIT_PAIR, 8'h3C, 1'b1, 1'b0, 1'b0);
    send_item(OP_BIT_PAIR, 8'hFF, 1'b1, 1'b1, 1'b1);
    // Targeted at an all-ones family: discrepancies follow the family byte,
    // then the first bit past byte 0 falls back to zero
    send_item(OP_RESTART, 8'hFF, 1'b1, 1'b1, 1'b1);
    repeat (9) send_item(OP_BIT_PAIR, 8'h00, 1'b0, 1'b0, 1'b0);
    // Targeted at family zero: zero picks inside the family byte
    send_item(OP_RESTART, 8'h00, 1'b1, 1'b0, 1'b0);
    repeat (2) send_item(OP_BIT_PAIR, 8'hFF, 1'b1, 1'b0, 1'b0);
    // Plain restart mid-pass, ignored family fields set
    send_item(OP_RESTART, 8'hA5, 1'b0, 1'b1, 1'b0);
    send_item(OP_BIT_PAIR, 8'h5A, 1'b1, 1'b1, 1'b0);
    send_item(OP_BIT_PAIR, 8'hA5, 1'b0, 1'b0, 1'b1);
    send_item(OP_RESTART, 8'h5A, 1'b1, 1'b0, 1'b1);
    repeat (2) send_item(OP_BIT_PAIR, 8'h00, 1'b0, 1'b0, 1'b0);

    // Random part in three phases of idling: sender mostly busy and receiver
    // mostly stalled, then the reverse, then both at full rate
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 14;
          rx_idle_pct = 86;
        end
        1: begin
          tx_idle_pct = 86;
          rx_idle_pct = 14;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      // Stop each phase once the running total passes its share
      budget = 150 * (phase + 1);
      while (items_sent < budget) begin
        // Open with one device that ends the search, then a zero family
        if (episode_cnt == 0) begin
          run_enumeration(1, 1'b0, 1'b0);
        end else if (episode_cnt == 1) begin
          run_enumeration(2, 1'b1, 1'b1);
        end else begin
          case ($urandom_range(3))
            0, 1: run_enumeration($urandom_range(3, 1), $urandom_range(7) == 0,
                                  $urandom_range(2) == 0);
            2: run_blind_passes();
            default: run_noise();
          endcase
        end
        episode_cnt++;
      end
    end

    // Drain: let every result come out, then allow the pipeline to settle
    wait_results();
    repeat (16) @(posedge clk);
    end_check <= 1'b1;
    @(posedge clk);
    end_check <= 1'b0;
    @(posedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
